FILE: src/i2cmbe_pkg.sv
package i2cmbe_pkg;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_S_HIGH = 4'd1,
    PH_S_LOW  = 4'd2,
    PH_P_LOW  = 4'd3,
    PH_P_HIGH = 4'd4,
    PH_W_DATA = 4'd5,
    PH_W_HIGH = 4'd6,
    PH_W_LOW  = 4'd7,
    PH_K_REL  = 4'd8,
    PH_K_HIGH = 4'd9,
    PH_K_POLL = 4'd10,
    PH_R_LOW  = 4'd11,
    PH_R_HIGH = 4'd12,
    PH_A_LOW  = 4'd13,
    PH_A_HIGH = 4'd14
  } phase_e;

  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_START    = 3'd1,
    ACT_STOP     = 3'd2,
    ACT_WRITE    = 3'd3,
    ACT_WAIT_ACK = 3'd4,
    ACT_READ     = 3'd5
  } action_e;

  // delay lengths as a left shift of the unit: 1, 2 or 4 units
  localparam logic [1:0] WAIT_1U = 2'd0;
  localparam logic [1:0] WAIT_2U = 2'd1;
  localparam logic [1:0] WAIT_4U = 2'd2;

  localparam logic CFG_UNIT_TICKS = 1'b0;
  localparam logic CFG_POLL_LIMIT = 1'b1;

  localparam logic [15:0] UNIT_TICKS_RST = 16'd100;
  localparam logic [7:0]  POLL_LIMIT_RST = 8'd250;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic       rd_ack;
    logic       sda_in;
  } in_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_fail;
  } out_t;

endpackage

FILE: src/i2cmbe_fsm.sv
module i2cmbe_fsm import i2cmbe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  in_t         in_i,
  input  logic [15:0] unit_ticks_i,
  input  logic [7:0]  poll_limit_i,
  output out_t        out_o
);

  phase_e      phase_q, phase_d;
  logic [19:0] delay_q, delay_d;
  logic [3:0]  bit_q, bit_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  poll_q, poll_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic        drive_q, drive_d;
  logic        ack_mode_q, ack_mode_d;
  logic        fail_q, fail_d;
  logic [7:0]  rx_q, rx_d;
  logic        done_q, done_d;

  logic        expired;
  logic [3:0]  bit_inc;
  logic        poll_out;
  logic        wait_load;
  logic [1:0]  wait_shift;
  logic [15:0] unit_eff;

  assign expired  = (delay_q <= 20'd1);
  assign bit_inc  = bit_q + 4'd1;
  assign poll_out = (poll_q >= poll_limit_i);
  assign unit_eff = (unit_ticks_i == 16'd0) ? 16'd1 : unit_ticks_i;

  // next phase and the wait that goes with it
  always_comb begin
    phase_d    = phase_q;
    wait_load  = 1'b0;
    wait_shift = WAIT_1U;
    if (phase_q == PH_IDLE) begin
      unique case (in_i.action)
        ACT_START: begin
          phase_d = PH_S_HIGH; wait_load = 1'b1; wait_shift = WAIT_4U;
        end
        ACT_STOP: begin
          phase_d = PH_P_LOW; wait_load = 1'b1; wait_shift = WAIT_4U;
        end
        ACT_WRITE: begin
          phase_d = PH_W_DATA; wait_load = 1'b1; wait_shift = WAIT_2U;
        end
        ACT_WAIT_ACK: begin
          phase_d = PH_K_REL; wait_load = 1'b1; wait_shift = WAIT_1U;
        end
        ACT_READ: begin
          phase_d = PH_R_LOW; wait_load = 1'b1; wait_shift = WAIT_2U;
        end
        default: ;
      endcase
    end else if (phase_q == PH_K_POLL) begin
      if (!in_i.sda_in) begin
        phase_d = PH_IDLE;
      end else if (poll_out) begin
        phase_d = PH_P_LOW; wait_load = 1'b1; wait_shift = WAIT_4U;
      end
    end else if (expired) begin
      unique case (phase_q)
        PH_S_HIGH: begin
          phase_d = PH_S_LOW; wait_load = 1'b1; wait_shift = WAIT_4U;
        end
        PH_P_LOW: begin
          phase_d = PH_P_HIGH; wait_load = 1'b1; wait_shift = WAIT_4U;
        end
        PH_W_DATA: begin
          phase_d = PH_W_HIGH; wait_load = 1'b1; wait_shift = WAIT_2U;
        end
        PH_W_HIGH: begin
          phase_d = PH_W_LOW; wait_load = 1'b1; wait_shift = WAIT_2U;
        end
        PH_W_LOW: begin
          if (bit_inc[3]) begin
            phase_d = PH_IDLE;
          end else begin
            phase_d = PH_W_DATA; wait_load = 1'b1; wait_shift = WAIT_2U;
          end
        end
        PH_K_REL: begin
          phase_d = PH_K_HIGH; wait_load = 1'b1; wait_shift = WAIT_1U;
        end
        PH_K_HIGH: phase_d = PH_K_POLL;
        PH_R_LOW: begin
          phase_d = PH_R_HIGH; wait_load = 1'b1; wait_shift = WAIT_1U;
        end
        PH_R_HIGH: begin
          phase_d    = bit_inc[3] ? PH_A_LOW : PH_R_LOW;
          wait_load  = 1'b1;
          wait_shift = WAIT_2U;
        end
        PH_A_LOW: begin
          phase_d = PH_A_HIGH; wait_load = 1'b1; wait_shift = WAIT_2U;
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    delay_d = delay_q;
    if (wait_load) begin
      delay_d = {4'd0, unit_eff} << wait_shift;
    end else if (phase_q != PH_IDLE && phase_q != PH_K_POLL) begin
      delay_d = expired ? 20'd0 : delay_q - 20'd1;
    end
  end

  // bus levels, shifter and status
  always_comb begin
    bit_d      = bit_q;
    shift_d    = shift_q;
    poll_d     = poll_q;
    scl_d      = scl_q;
    sda_d      = sda_q;
    drive_d    = drive_q;
    ack_mode_d = ack_mode_q;
    fail_d     = fail_q;
    rx_d       = rx_q;
    done_d     = 1'b0;
    if (phase_q == PH_IDLE) begin
      unique case (in_i.action)
        ACT_START: begin
          drive_d = 1'b1; sda_d = 1'b1; scl_d = 1'b1;
        end
        ACT_STOP: begin
          drive_d = 1'b1; scl_d = 1'b0; sda_d = 1'b0;
        end
        ACT_WRITE: begin
          drive_d = 1'b1;
          scl_d   = 1'b0;
          sda_d   = in_i.tx_byte[7];
          shift_d = {in_i.tx_byte[6:0], 1'b0};
          bit_d   = 4'd0;
        end
        ACT_WAIT_ACK: begin
          drive_d = 1'b0; sda_d = 1'b1; fail_d = 1'b0; poll_d = 8'd0;
        end
        ACT_READ: begin
          drive_d    = 1'b0;
          scl_d      = 1'b0;
          shift_d    = 8'd0;
          bit_d      = 4'd0;
          ack_mode_d = in_i.rd_ack;
        end
        default: ;
      endcase
    end else if (phase_q == PH_K_POLL) begin
      if (!in_i.sda_in) begin
        scl_d  = 1'b0;
        done_d = 1'b1;
      end else if (poll_out) begin
        // timeout: straight into a stop
        fail_d  = 1'b1;
        drive_d = 1'b1;
        scl_d   = 1'b0;
        sda_d   = 1'b0;
      end else begin
        poll_d = poll_q + 8'd1;
      end
    end else if (expired) begin
      unique case (phase_q)
        PH_S_HIGH: sda_d = 1'b0;
        PH_S_LOW: begin
          scl_d = 1'b0; done_d = 1'b1;
        end
        PH_P_LOW: begin
          scl_d = 1'b1; sda_d = 1'b1;
        end
        PH_P_HIGH: done_d = 1'b1;
        PH_W_DATA: scl_d = 1'b1;
        PH_W_HIGH: scl_d = 1'b0;
        PH_W_LOW: begin
          bit_d = bit_inc;
          if (bit_inc[3]) begin
            done_d = 1'b1;
          end else begin
            sda_d   = shift_q[7];
            shift_d = {shift_q[6:0], 1'b0};
          end
        end
        PH_K_REL: scl_d = 1'b1;
        PH_R_LOW: begin
          scl_d   = 1'b1;
          shift_d = {shift_q[6:0], in_i.sda_in};
        end
        PH_R_HIGH: begin
          bit_d = bit_inc;
          scl_d = 1'b0;
          if (bit_inc[3]) begin
            rx_d    = shift_q;
            drive_d = 1'b1;
            sda_d   = ~ack_mode_q;
          end
        end
        PH_A_LOW: scl_d = 1'b1;
        PH_A_HIGH: begin
          scl_d = 1'b0; done_d = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      delay_q    <= 20'd0;
      bit_q      <= 4'd0;
      shift_q    <= 8'd0;
      poll_q     <= 8'd0;
      scl_q      <= 1'b1;
      sda_q      <= 1'b1;
      drive_q    <= 1'b1;
      ack_mode_q <= 1'b0;
      fail_q     <= 1'b0;
      rx_q       <= 8'd0;
      done_q     <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      delay_q    <= delay_d;
      bit_q      <= bit_d;
      shift_q    <= shift_d;
      poll_q     <= poll_d;
      scl_q      <= scl_d;
      sda_q      <= sda_d;
      drive_q    <= drive_d;
      ack_mode_q <= ack_mode_d;
      fail_q     <= fail_d;
      rx_q       <= rx_d;
      done_q     <= done_d;
    end
  end

  // state only moves on an accepted transaction, so it doubles as the result register
  assign out_o.scl       = scl_q;
  assign out_o.sda_out   = sda_q;
  assign out_o.sda_drive = drive_q;
  assign out_o.busy_res  = (phase_q != PH_IDLE);
  assign out_o.done_res  = done_q;
  assign out_o.rx_byte   = rx_q;
  assign out_o.ack_fail  = fail_q;

endmodule

FILE: src/i2c_master_bit_engine_core.sv
// Byte-level I2C master. Each input transaction is one tick of bus time and
// carries a command code, the byte to write, the ACK/NACK choice for a read
// and the sampled SDA level. Commands (start, stop, write, wait ack, read)
// are taken only while the engine is idle; anything else is ignored.
// Each input transaction produces exactly one output transaction holding the
// SCL/SDA levels after that tick, busy, a one-tick done pulse, the last
// received byte and the ACK timeout flag.
// Output: the result is registered and appears in the cycle after the input is taken.
// Throughput: one transaction per cycle while in_stall_o is low, set by the single state update
// stage whose registers also form the result register.
// in_stall_o is raised only while a result is held and out_stall_i is high;
// the held result does not change until it is taken.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i
// (0 unit_ticks, 1 ack_poll_limit); write only while idle.
// Reset: bus released high with SDA driven, idle, unit_ticks 100,
// ack_poll_limit 250, no result pending.
module i2c_master_bit_engine_core import i2cmbe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  logic [15:0] unit_ticks_q;
  logic [7:0]  poll_limit_q;
  logic        out_valid_q, out_valid_d;
  logic        step;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign step       = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_ticks_q <= UNIT_TICKS_RST;
      poll_limit_q <= POLL_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_UNIT_TICKS: unit_ticks_q <= cfg_data_i;
        CFG_POLL_LIMIT: poll_limit_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (step) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  i2cmbe_fsm u_fsm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .in_i         (in_data_i),
    .unit_ticks_i (unit_ticks_q),
    .poll_limit_i (poll_limit_q),
    .out_o        (out_data_o)
  );

  assign out_valid_o = out_valid_q;

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted transaction produced no result");

  a_taken_without_input_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !in_valid_i |=> !out_valid_o)
    else $error("result repeated after it was taken");

  a_done_means_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.done_res |-> !out_data_o.busy_res)
    else $error("done reported while still busy");

  a_stalled_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

FILE: dv/tb_i2c_master_bit_engine_core.sv
`timescale 1ns / 1ps

module tb_i2c_master_bit_engine_core;
  import i2cmbe_pkg::*;

  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          NEVER_ACK      = 1000;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          PHASE_TICKS    = 30;
  localparam logic [2:0]  ACT_BAD_6      = 3'd6;
  localparam logic [2:0]  ACT_BAD_7      = 3'd7;

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_t         in_data_i  = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_t        out_data_o;
  logic        cfg_we_i   = 1'b0;
  logic        cfg_idx_i  = 1'b0;
  logic [15:0] cfg_data_i = '0;

  i2c_master_bit_engine_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // predicted engine state and register copies
  logic [15:0] unit_ticks_cfg;
  logic [7:0]  poll_limit_cfg;
  phase_e      eng_phase;
  logic [19:0] eng_delay;
  logic [3:0]  eng_bit;
  logic [7:0]  eng_shift;
  logic [7:0]  eng_polls;
  logic        eng_scl, eng_sda, eng_drive, eng_ack_sel, eng_fail;
  logic [7:0]  eng_rx;

  out_t bus_expect_q[$];
  int   mismatches    = 0;
  int   items_sent    = 0;
  int   tx_gap_pct    = 0;
  int   rx_stall_pct  = 0;
  int   hold_left     = 0;
  int   quiet_cycles  = 0;

  task automatic reset_model();
    unit_ticks_cfg = UNIT_TICKS_RST;
    poll_limit_cfg = POLL_LIMIT_RST;
    eng_phase   = PH_IDLE;
    eng_delay   = '0;
    eng_bit     = '0;
    eng_shift   = '0;
    eng_polls   = '0;
    eng_scl     = 1'b1;
    eng_sda     = 1'b1;
    eng_drive   = 1'b1;
    eng_ack_sel = 1'b0;
    eng_fail    = 1'b0;
    eng_rx      = '0;
  endtask

  // a unit of zero counts as one
  task automatic arm_delay(input int unsigned units, input phase_e nxt);
    int unsigned u;
    u = (unit_ticks_cfg == 16'd0) ? 1 : int'(unit_ticks_cfg);
    eng_delay = 20'(units * u);
    eng_phase = nxt;
  endtask

  task automatic shift_out_bit();
    eng_sda   = eng_shift[7];
    eng_shift = {eng_shift[6:0], 1'b0};
    arm_delay(2, PH_W_DATA);
  endtask

  task automatic begin_stop();
    eng_drive = 1'b1;
    eng_scl   = 1'b0;
    eng_sda   = 1'b0;
    arm_delay(4, PH_P_LOW);
  endtask

  // one bus tick: bus levels and status after the tick
  task automatic engine_tick(input in_t item, output out_t res);
    logic done;
    done = 1'b0;
    if (eng_phase == PH_IDLE) begin
      case (item.action)
        ACT_START: begin
          eng_drive = 1'b1;
          eng_sda   = 1'b1;
          eng_scl   = 1'b1;
          arm_delay(4, PH_S_HIGH);
        end
        ACT_STOP: begin_stop();
        ACT_WRITE: begin
          eng_drive = 1'b1;
          eng_scl   = 1'b0;
          eng_shift = item.tx_byte;
          eng_bit   = '0;
          shift_out_bit();
        end
        ACT_WAIT_ACK: begin
          eng_drive = 1'b0;
          eng_sda   = 1'b1;
          eng_fail  = 1'b0;
          eng_polls = '0;
          arm_delay(1, PH_K_REL);
        end
        ACT_READ: begin
          eng_drive   = 1'b0;
          eng_scl     = 1'b0;
          eng_shift   = '0;
          eng_bit     = '0;
          eng_ack_sel = item.rd_ack;
          arm_delay(2, PH_R_LOW);
        end
        default: ;
      endcase
    end else if (eng_phase == PH_K_POLL) begin
      if (!item.sda_in) begin
        eng_scl   = 1'b0;
        eng_phase = PH_IDLE;
        done      = 1'b1;
      end else if (eng_polls >= poll_limit_cfg) begin
        eng_fail = 1'b1;
        begin_stop();
      end else begin
        eng_polls = eng_polls + 8'd1;
      end
    end else if (eng_delay > 20'd1) begin
      eng_delay = eng_delay - 20'd1;
    end else begin
      eng_delay = '0;
      case (eng_phase)
        PH_S_HIGH: begin
          eng_sda = 1'b0;
          arm_delay(4, PH_S_LOW);
        end
        PH_S_LOW: begin
          eng_scl   = 1'b0;
          eng_phase = PH_IDLE;
          done      = 1'b1;
        end
        PH_P_LOW: begin
          eng_scl = 1'b1;
          eng_sda = 1'b1;
          arm_delay(4, PH_P_HIGH);
        end
        PH_P_HIGH: begin
          eng_phase = PH_IDLE;
          done      = 1'b1;
        end
        PH_W_DATA: begin
          eng_scl = 1'b1;
          arm_delay(2, PH_W_HIGH);
        end
        PH_W_HIGH: begin
          eng_scl = 1'b0;
          arm_delay(2, PH_W_LOW);
        end
        PH_W_LOW: begin
          eng_bit = eng_bit + 4'd1;
          if (eng_bit >= 4'd8) begin
            eng_phase = PH_IDLE;
            done      = 1'b1;
          end else begin
            shift_out_bit();
          end
        end
        PH_K_REL: begin
          eng_scl = 1'b1;
          arm_delay(1, PH_K_HIGH);
        end
        PH_K_HIGH: eng_phase = PH_K_POLL;
        PH_R_LOW: begin
          eng_scl   = 1'b1;
          eng_shift = {eng_shift[6:0], item.sda_in};
          arm_delay(1, PH_R_HIGH);
        end
        PH_R_HIGH: begin
          eng_bit = eng_bit + 4'd1;
          eng_scl = 1'b0;
          if (eng_bit >= 4'd8) begin
            eng_rx    = eng_shift;
            eng_drive = 1'b1;
            eng_sda   = ~eng_ack_sel;
            arm_delay(2, PH_A_LOW);
          end else begin
            arm_delay(2, PH_R_LOW);
          end
        end
        PH_A_LOW: begin
          eng_scl = 1'b1;
          arm_delay(2, PH_A_HIGH);
        end
        PH_A_HIGH: begin
          eng_scl   = 1'b0;
          eng_phase = PH_IDLE;
          done      = 1'b1;
        end
        default: eng_phase = PH_IDLE;
      endcase
    end
    res.scl       = eng_scl;
    res.sda_out   = eng_sda;
    res.sda_drive = eng_drive;
    res.busy_res  = (eng_phase != PH_IDLE);
    res.done_res  = done;
    res.rx_byte   = eng_rx;
    res.ack_fail  = eng_fail;
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got_v,
                             input logic [7:0] want_v);
    if (got_v !== want_v)
      report_mismatch($sformatf("%s got %0h want %0h", name, got_v, want_v));
  endtask

  // receiving side: stall, hold-off and result check
  always @(posedge clk_i) begin
    out_t want;
    out_t got;
    if (out_valid_o && !out_stall_i) begin
      if (bus_expect_q.size() == 0) begin
        report_mismatch("result with no transaction outstanding");
      end else begin
        want = bus_expect_q.pop_front();
        got  = out_data_o;
        check_field("scl", 8'(got.scl), 8'(want.scl));
        check_field("sda_out", 8'(got.sda_out), 8'(want.sda_out));
        check_field("sda_drive", 8'(got.sda_drive), 8'(want.sda_drive));
        check_field("busy", 8'(got.busy_res), 8'(want.busy_res));
        check_field("done", 8'(got.done_res), 8'(want.done_res));
        check_field("rx_byte", got.rx_byte, want.rx_byte);
        check_field("ack_fail", 8'(got.ack_fail), 8'(want.ack_fail));
      end
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_tick(input in_t item);
    out_t predicted;
    while ($urandom_range(99) < tx_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    engine_tick(item, predicted);
    bus_expect_q.push_back(predicted);
    items_sent++;
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] value);
    in_valid_i <= 1'b0;
    while (bus_expect_q.size() != 0) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_UNIT_TICKS) unit_ticks_cfg = value;
    else poll_limit_cfg = value[7:0];
    @(posedge clk_i);
  endtask

  task automatic set_poll_limit(input logic [7:0] limit);
    write_reg(CFG_POLL_LIMIT, {8'($urandom), limit});
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      1: begin tx_gap_pct = 51; rx_stall_pct = 0;  end
      2: begin tx_gap_pct = 0;  rx_stall_pct = 51; end
      3: begin tx_gap_pct = 6;  rx_stall_pct = 6;  end
      default: begin tx_gap_pct = 0; rx_stall_pct = 0; end
    endcase
  endtask

  // issue a command while idle, then keep the bus ticking until it finishes;
  // during ACK polling SDA is held high for ack_after polls, then pulled low
  task automatic run_command(input logic [2:0] act, input logic [7:0] tx,
                             input logic ack_sel, input int ack_after);
    in_t item;
    int  polls_seen;
    polls_seen     = 0;
    item           = in_t'(13'($urandom));
    item.action    = act;
    item.tx_byte   = tx;
    item.rd_ack    = ack_sel;
    send_tick(item);
    while (eng_phase != PH_IDLE) begin
      item = in_t'(13'($urandom));
      if (eng_phase == PH_K_POLL) begin
        item.sda_in = (polls_seen < ack_after);
        polls_seen++;
      end
      send_tick(item);
    end
  endtask

  task automatic idle_noise(input int n);
    in_t item;
    repeat (n) begin
      item = in_t'(13'($urandom));
      case ($urandom_range(2))
        0: item.action = ACT_NONE;
        1: item.action = ACT_BAD_6;
        default: item.action = ACT_BAD_7;
      endcase
      send_tick(item);
    end
  endtask

  function automatic int pick_ack_delay();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(3);
    if (r < 85) return int'(poll_limit_cfg);  // last poll that still passes
    return NEVER_ACK;
  endfunction

  // reset unit length: one wait-ack with a prompt ACK
  task automatic test_default_timing();
    set_idling(0);
    idle_noise(1);
    run_command(ACT_WAIT_ACK, 8'h00, 1'b0, 0);
  endtask

  task automatic test_directed_edges();
    write_reg(CFG_UNIT_TICKS, 16'd1);
    set_poll_limit(8'd1);
    idle_noise(2);
    run_command(ACT_START, 8'h00, 1'b0, 0);
    run_command(ACT_WRITE, 8'hA5, 1'b0, 0);
    run_command(ACT_WAIT_ACK, 8'h00, 1'b0, 0);
    run_command(ACT_WAIT_ACK, 8'h00, 1'b0, 1);
    run_command(ACT_WAIT_ACK, 8'hFF, 1'b1, NEVER_ACK);
    run_command(ACT_READ, 8'h00, 1'b1, 0);
    run_command(ACT_READ, 8'hFF, 1'b0, 0);
    run_command(ACT_STOP, 8'h00, 1'b0, 0);
    // zero unit and zero poll limit
    write_reg(CFG_UNIT_TICKS, 16'd0);
    set_poll_limit(8'd0);
    run_command(ACT_START, 8'h5A, 1'b0, 0);
    run_command(ACT_WAIT_ACK, 8'h00, 1'b0, NEVER_ACK);
    run_command(ACT_WAIT_ACK, 8'h00, 1'b0, 0);
  endtask

  task automatic test_random_traffic();
    int goal;
    int r;
    logic [7:0] limits[5];
    logic [15:0] units[4];
    units  = '{16'd0, 16'd1, 16'd1, 16'd2};
    for (int mode = 0; mode < 4; mode++) begin
      limits = '{8'd0, 8'd1, 8'd2, 8'd3, 8'($urandom_range(5))};
      set_idling(mode);
      write_reg(CFG_UNIT_TICKS, units[$urandom_range(3)]);
      set_poll_limit(limits[$urandom_range(4)]);
      goal = items_sent + PHASE_TICKS;
      while (items_sent < goal) begin
        r = $urandom_range(99);
        if (r < 85) begin
          run_command(3'($urandom_range(ACT_START, ACT_READ)), 8'($urandom),
                      1'($urandom), pick_ack_delay());
        end else begin
          idle_noise($urandom_range(1, 4));
        end
      end
    end
  endtask

  // receiver holds off while the sender keeps offering ticks
  task automatic test_output_backpressure();
    set_idling(0);
    write_reg(CFG_UNIT_TICKS, 16'd1);
    set_poll_limit(8'd4);
    hold_left = HOLD_CYCLES;
    run_command(ACT_WRITE, 8'($urandom), 1'($urandom), 0);
  endtask

  initial begin
    reset_model();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_timing();
    test_directed_edges();
    test_random_traffic();
    test_output_backpressure();
    in_valid_i <= 1'b0;
    while (bus_expect_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
